[sv/gps_time_to_utc_calendar_defines.svh]
// Assertion macros for the checker file of the GPS to UTC calendar block.
`ifndef GPS_TIME_TO_UTC_CALENDAR_DEFINES_SVH
`define GPS_TIME_TO_UTC_CALENDAR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GTUC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GTUC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/gtuc_pkg.sv]
// Types and constants for the GPS time to UTC calendar pipeline.
package gtuc_pkg;

  // Leap second thresholds in GPS seconds, ascending.
  localparam int LeapTableLen = 16;
  localparam longint LeapGps [LeapTableLen] = '{
    46828800, 78364801, 109900802, 173059203,
    252028804, 315187205, 346723206, 393984007,
    425520008, 457056009, 504489610, 551750411,
    599184012, 820108813, 914803214, 1025136015
  };
  localparam longint GpsAdjust = 1000000000;

  // adjusted + 1e9 (GPS) + 315964800 (Unix epoch) + 719468 days (0000-03-01 base)
  localparam longint UnixBias = 64'sd63478000000;

  // 86400 = 2^7 * 675; the odd part is taken by reciprocal multiply.
  localparam int     SecsLowBits   = 7;
  localparam int     DayOddDiv     = 675;
  localparam int     DayRecipShift = 39;
  localparam longint DayRecip      = ((longint'(1) <<< DayRecipShift) + DayOddDiv - 1)
                                     / DayOddDiv;

  // Day count of 400 year eras; every reachable day number lies in era four or five.
  localparam int EraDays = 146097;
  localparam int EraFourStart = 4 * EraDays;
  localparam int EraFiveStart = 5 * EraDays;
  localparam int EraFourYear  = 1600;
  localparam int EraFiveYear  = 2000;

  localparam int     R1460Shift = 29;
  localparam longint R1460      = ((longint'(1) <<< R1460Shift) + 1459) / 1460;
  localparam int     R36524Shift = 34;
  localparam longint R36524      = ((longint'(1) <<< R36524Shift) + 36523) / 36524;
  localparam int     R365Shift = 27;
  localparam longint R365      = ((longint'(1) <<< R365Shift) + 364) / 365;
  localparam int     EraLastDay = 146096;

  // First day of each month in a March-based year.
  localparam logic [8:0] MonthStart [12] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };
  localparam int MarchBasedJan = 10;

  typedef struct packed {
    logic [35:0] secs;   // seconds since 0000-03-01
    logic [4:0]  leaps;
  } front_t;

  typedef struct packed {
    logic [16:0] sod;
    logic [17:0] doe;    // day of era
    logic        era_hi; // era five rather than four
    logic [4:0]  leaps;
  } split_t;

endpackage

[sv/gtuc_front.sv]
// Leap count and rebasing of the seconds count, two pipeline stages.
module gtuc_front #(
  parameter int FracW       = 20,
  parameter int LeapEntries = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [32:0]  adj_i,
  input  logic [FracW-1:0]    frac_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gtuc_pkg::front_t    front_o,
  output logic [FracW-1:0]    frac_o
);

  localparam int LeapUsed = (LeapEntries < gtuc_pkg::LeapTableLen) ?
                            LeapEntries : gtuc_pkg::LeapTableLen;

  logic signed [33:0] adj_ext;
  logic [LeapUsed-1:0] reached;
  logic [36:0] sum_d;
  logic [4:0]  leaps_d;

  logic              v1_q, v2_q, rdy1, rdy2;
  logic [35:0]       secs1_q;
  logic [4:0]        leaps1_q;
  logic [FracW-1:0]  frac1_q, frac2_q;
  gtuc_pkg::front_t  front_q, front_d;

  // thresholds ascend, so the reached set is a prefix and its size is the scan count
  always_comb begin
    adj_ext = {adj_i[32], adj_i};
    for (int i = 0; i < LeapUsed; i++) begin
      reached[i] = adj_ext >= $signed(34'(gtuc_pkg::LeapGps[i] - gtuc_pkg::GpsAdjust));
    end
    leaps_d = 5'($countones(reached));
    sum_d   = {{4{adj_i[32]}}, adj_i} + 37'(gtuc_pkg::UnixBias);
  end

  always_comb begin
    front_d.secs  = secs1_q - 36'(leaps1_q);
    front_d.leaps = leaps1_q;
  end

  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      secs1_q  <= sum_d[35:0];
      leaps1_q <= leaps_d;
      frac1_q  <= frac_i;
    end
    if (rdy2 && v1_q) begin
      front_q <= front_d;
      frac2_q <= frac1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign front_o     = front_q;
  assign frac_o      = frac2_q;

endmodule

[sv/gtuc_split.sv]
// Day number and seconds of day by reciprocal multiply, two pipeline stages.
module gtuc_split #(
  parameter int FracW = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gtuc_pkg::front_t  front_i,
  input  logic [FracW-1:0]  frac_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gtuc_pkg::split_t  split_o,
  output logic [FracW-1:0]  frac_o
);

  localparam int OddW = 36 - gtuc_pkg::SecsLowBits;

  logic [OddW-1:0]   odd_in, odd3;
  logic [58:0]       day_prod;
  logic [19:0]       days_d;
  logic [29:0]       back_prod;
  logic [OddW-1:0]   rem;
  gtuc_pkg::split_t  split_d, split_q;

  logic              v3_q, v4_q, rdy3, rdy4;
  logic [19:0]       days_q;
  logic [35:0]       secs3_q;
  logic [4:0]        leaps3_q;
  logic [FracW-1:0]  frac3_q, frac4_q;

  always_comb begin
    odd_in   = front_i.secs[35:gtuc_pkg::SecsLowBits];
    day_prod = 59'(odd_in) * 59'(gtuc_pkg::DayRecip);
    days_d   = day_prod[58:gtuc_pkg::DayRecipShift];
  end

  always_comb begin
    odd3           = secs3_q[35:gtuc_pkg::SecsLowBits];
    back_prod      = 30'(days_q) * 30'(gtuc_pkg::DayOddDiv);
    rem            = odd3 - OddW'(back_prod);
    split_d.sod    = {rem[9:0], secs3_q[gtuc_pkg::SecsLowBits-1:0]};
    split_d.era_hi = days_q >= 20'(gtuc_pkg::EraFiveStart);
    split_d.doe    = 18'(days_q - (split_d.era_hi ? 20'(gtuc_pkg::EraFiveStart) :
                                                    20'(gtuc_pkg::EraFourStart)));
    split_d.leaps  = leaps3_q;
  end

  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign in_ready_o = rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy3) v3_q <= in_valid_i;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && in_valid_i) begin
      days_q   <= days_d;
      secs3_q  <= front_i.secs;
      leaps3_q <= front_i.leaps;
      frac3_q  <= frac_i;
    end
    if (rdy4 && v3_q) begin
      split_q <= split_d;
      frac4_q <= frac3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign split_o     = split_q;
  assign frac_o      = frac4_q;

endmodule

[sv/gtuc_civil.sv]
// Day of era to year, month and day, four pipeline stages ending in the output register.
module gtuc_civil #(
  parameter int FracW = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gtuc_pkg::split_t  split_i,
  input  logic [FracW-1:0]  frac_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [11:0]       year_o,
  output logic [3:0]        month_o,
  output logic [4:0]        mday_o,
  output logic [16:0]       sod_o,
  output logic [FracW-1:0]  frac_o,
  output logic [4:0]        leaps_o
);

  logic              v5_q, v6_q, v7_q, v8_q;
  logic              rdy5, rdy6, rdy7, rdy8;
  gtuc_pkg::split_t  s5_q, s6_q, s7_q;
  logic [FracW-1:0]  frac5_q, frac6_q, frac7_q, frac8_q;

  // stage 5
  logic [36:0] p1460, p36524;
  logic [7:0]  q1460_d, q1460_q;
  logic [2:0]  q36524_d, q36524_q;
  logic        last_d, last_q;
  // stage 6
  logic [17:0] num;
  logic [36:0] p365;
  logic [8:0]  yoe_d, yoe6_q, yoe7_q;
  // stage 7
  logic [1:0]  cent;
  logic [17:0] yday_base;
  logic [8:0]  doy_d, doy_q;
  // stage 8
  logic [11:1] past;
  logic [3:0]  mp;
  logic [11:0] year_d, year_q;
  logic [3:0]  month_d, month_q;
  logic [4:0]  mday_d, mday_q;
  logic [16:0] sod_q;
  logic [4:0]  leaps_q;

  always_comb begin
    p1460    = 37'(split_i.doe) * 37'(gtuc_pkg::R1460);
    p36524   = 37'(split_i.doe) * 37'(gtuc_pkg::R36524);
    q1460_d  = p1460[36:gtuc_pkg::R1460Shift];
    q36524_d = p36524[36:gtuc_pkg::R36524Shift];
    last_d   = split_i.doe >= 18'(gtuc_pkg::EraLastDay);
  end

  // year of era from the day of era
  always_comb begin
    num   = s5_q.doe - 18'(q1460_q) + 18'(q36524_q) - 18'(last_q);
    p365  = 37'(num) * 37'(gtuc_pkg::R365);
    yoe_d = p365[35:gtuc_pkg::R365Shift];
  end

  // day of a March-based year
  always_comb begin
    if (yoe6_q >= 9'd300)      cent = 2'd3;
    else if (yoe6_q >= 9'd200) cent = 2'd2;
    else if (yoe6_q >= 9'd100) cent = 2'd1;
    else                       cent = 2'd0;
    yday_base = 18'(yoe6_q) * 18'd365 + 18'(yoe6_q[8:2]) - 18'(cent);
    doy_d     = 9'(s6_q.doe - yday_base);
  end

  always_comb begin
    for (int k = 1; k < 12; k++) begin
      past[k] = doy_q >= gtuc_pkg::MonthStart[k];
    end
    mp      = 4'($countones(past));
    mday_d  = 5'(doy_q - gtuc_pkg::MonthStart[mp] + 9'd1);
    month_d = (mp < 4'(gtuc_pkg::MarchBasedJan)) ? mp + 4'd2 :
                                                   mp - 4'(gtuc_pkg::MarchBasedJan);
    year_d  = 12'(yoe7_q)
            + (s7_q.era_hi ? 12'(gtuc_pkg::EraFiveYear) : 12'(gtuc_pkg::EraFourYear))
            + 12'(mp >= 4'(gtuc_pkg::MarchBasedJan));
  end

  assign rdy8       = !v8_q || out_ready_i;
  assign rdy7       = !v7_q || rdy8;
  assign rdy6       = !v6_q || rdy7;
  assign rdy5       = !v5_q || rdy6;
  assign in_ready_o = rdy5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else begin
      if (rdy5) v5_q <= in_valid_i;
      if (rdy6) v6_q <= v5_q;
      if (rdy7) v7_q <= v6_q;
      if (rdy8) v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && in_valid_i) begin
      s5_q     <= split_i;
      frac5_q  <= frac_i;
      q1460_q  <= q1460_d;
      q36524_q <= q36524_d;
      last_q   <= last_d;
    end
    if (rdy6 && v5_q) begin
      s6_q    <= s5_q;
      frac6_q <= frac5_q;
      yoe6_q  <= yoe_d;
    end
    if (rdy7 && v6_q) begin
      s7_q    <= s6_q;
      frac7_q <= frac6_q;
      yoe7_q  <= yoe6_q;
      doy_q   <= doy_d;
    end
    if (rdy8 && v7_q) begin
      year_q  <= year_d;
      month_q <= month_d;
      mday_q  <= mday_d;
      sod_q   <= s7_q.sod;
      leaps_q <= s7_q.leaps;
      frac8_q <= frac7_q;
    end
  end

  assign out_valid_o = v8_q;
  assign year_o      = year_q;
  assign month_o     = month_q;
  assign mday_o      = mday_q;
  assign sod_o       = sod_q;
  assign frac_o      = frac8_q;
  assign leaps_o     = leaps_q;

endmodule

[sv/gps_time_to_utc_calendar.sv]
// GPS to UTC calendar converter. One beat in per clock while the output is not stalled.
// The adjusted GPS seconds (GPS minus 1e9) are rebased to GPS seconds, the leap
// seconds reached in the fixed sixteen-entry table are counted and removed, and the
// resulting UTC seconds are split into proleptic Gregorian year, zero-based month,
// day of month and seconds of day; the fraction and the leap count ride along. The
// pipeline is eight register stages (two leap/rebase, two day split, four calendar),
// each with its own valid bit, so it takes a new beat every cycle while the output is not
// stalled and holds one result per stage when it is; a stage that is empty keeps accepting,
// so bubbles close up. Throughput is one beat per cycle with no stall.
// The block keeps no state between beats. Times before 1970 are handled by floor
// semantics: seconds of day stays in 0..86399.
module gps_time_to_utc_calendar #(
  parameter int FRACTION_BITS = 20, // fraction width, 8..32
  parameter int LEAP_ENTRIES  = 16  // table entries scanned, 1..64; at most 16 are used
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [32:0]       adjusted_seconds_i,
  input  logic [FRACTION_BITS-1:0] fraction_magnitude_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [11:0]              calendar_year_o,
  output logic [3:0]               month_index_o,
  output logic [4:0]               day_of_month_o,
  output logic [16:0]              seconds_of_day_o,
  output logic [FRACTION_BITS-1:0] fraction_out_o,
  output logic [4:0]               leap_count_o
);

  logic                     fr_valid, fr_ready, sp_valid, sp_ready;
  gtuc_pkg::front_t         fr_beat;
  gtuc_pkg::split_t         sp_beat;
  logic [FRACTION_BITS-1:0] fr_frac, sp_frac;

  // stages 1-2: leap count, rebase to seconds since 0000-03-01
  gtuc_front #(
    .FracW       (FRACTION_BITS),
    .LeapEntries (LEAP_ENTRIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .adj_i       (adjusted_seconds_i),
    .frac_i      (fraction_magnitude_i),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .front_o     (fr_beat),
    .frac_o      (fr_frac)
  );

  // stages 3-4: day number, seconds of day, era
  gtuc_split #(
    .FracW (FRACTION_BITS)
  ) u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .front_i     (fr_beat),
    .frac_i      (fr_frac),
    .out_valid_o (sp_valid),
    .out_ready_i (sp_ready),
    .split_o     (sp_beat),
    .frac_o      (sp_frac)
  );

  // stages 5-8: year of era, day of year, month and day; stage 8 drives the ports
  gtuc_civil #(
    .FracW (FRACTION_BITS)
  ) u_civil (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sp_valid),
    .in_ready_o  (sp_ready),
    .split_i     (sp_beat),
    .frac_i      (sp_frac),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .year_o      (calendar_year_o),
    .month_o     (month_index_o),
    .mday_o      (day_of_month_o),
    .sod_o       (seconds_of_day_o),
    .frac_o      (fraction_out_o),
    .leaps_o     (leap_count_o)
  );

endmodule

[sv/gtuc_checker.sv]
// Port-level checks for the GPS to UTC calendar converter, bound to the top level.
`include "gps_time_to_utc_calendar_defines.svh"

module gtuc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [11:0] calendar_year_o,
  input logic [3:0]  month_index_o,
  input logic [4:0]  day_of_month_o,
  input logic [16:0] seconds_of_day_o,
  input logic [4:0]  leap_count_o
);

  // stalled result beat holds
  `GTUC_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(calendar_year_o) && $stable(month_index_o) && $stable(day_of_month_o) && $stable(seconds_of_day_o) && $stable(leap_count_o), "stalled result beat changed")

  // with the output stage empty nothing upstream can be blocked
  `GTUC_ASSERT_IMP(a_idle_ready, !out_valid_o, in_ready_o, "input blocked with empty output stage")

  `GTUC_ASSERT_IMP(a_fields_range, out_valid_o, month_index_o <= 4'd11 && day_of_month_o != 5'd0 && seconds_of_day_o < 17'd86400 && leap_count_o <= 5'd16, "calendar field out of range")

  // last table threshold lies at mid 2012
  `GTUC_ASSERT_IMP(a_leap_year, out_valid_o && leap_count_o == 5'd16, calendar_year_o >= 12'd2012, "full leap count on an early year")

endmodule

bind gps_time_to_utc_calendar gtuc_checker u_gtuc_checker (.*);

[test/gps_time_to_utc_calendar_tb.sv]
// Self-checking testbench for the GPS time to UTC calendar converter.
module gps_time_to_utc_calendar_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Offsets between the time scales: adjusted GPS -> GPS -> Unix.
  localparam longint GPS_SHIFT  = 1000000000;
  localparam longint UNIX_SHIFT = 315964800;
  localparam longint DAY_SECS   = 86400;
  localparam int     LEAP_COUNT = 16;
  localparam int     MAX_REPORTS = 10;
  localparam int     RANDOM_BEATS = 1830;
  localparam int     DRAIN_EVERY  = 450;
  localparam int     MODE_BLOCK   = 100;
  localparam int     TAIL_CYCLES  = 24;   // pipeline is 8 deep; leave margin

  // How a side spaces its beats.
  typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_e;

  // One calendar breakdown, laid out as the result ports.
  typedef struct {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [16:0] sod;
    logic [19:0] frac;
    logic [4:0]  leaps;
  } calendar_t;

  // Expected-result store plus the conversion it predicts with.
  class calendar_scoreboard;
    calendar_t calendar_due_q[$];
    int        mismatches;
    int        checked;
    int        pre_1970;
    int        leap_hits[17];
    int        year_lo = 4095;
    int        year_hi = 0;

    // Leap second thresholds in GPS seconds, ascending.
    static function longint leap_gps(int k);
      case (k)
        0:  return 46828800;
        1:  return 78364801;
        2:  return 109900802;
        3:  return 173059203;
        4:  return 252028804;
        5:  return 315187205;
        6:  return 346723206;
        7:  return 393984007;
        8:  return 425520008;
        9:  return 457056009;
        10: return 504489610;
        11: return 551750411;
        12: return 599184012;
        13: return 820108813;
        14: return 914803214;
        default: return 1025136015;
      endcase
    endfunction

    static function longint floor_quot(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q = q - 1;
      return q;
    endfunction

    static function calendar_t utc_breakdown(logic signed [32:0] secs, logic [19:0] frac);
      calendar_t r;
      longint    gps, unix_s, days, sod, z, era, doe, yoe, doy, mp, d, m, y;
      int        n;
      gps = longint'(secs) + GPS_SHIFT;
      n = 0;
      while (n < LEAP_COUNT && gps >= leap_gps(n)) n++;
      unix_s = gps + UNIX_SHIFT - n;
      days   = floor_quot(unix_s, DAY_SECS);
      sod    = unix_s - days * DAY_SECS;
      // civil date from day count, March-based year inside a 400-year era
      z   = days + 719468;
      era = floor_quot(z, 146097);
      doe = z - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      d   = doy - (153 * mp + 2) / 5 + 1;
      m   = (mp < 10) ? mp + 3 : mp - 9;
      y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
      r.year  = y[11:0];
      r.month = 4'(m - 1);
      r.mday  = d[4:0];
      r.sod   = sod[16:0];
      r.frac  = frac;
      r.leaps = 5'(n);
      return r;
    endfunction

    function void note_input(logic signed [32:0] secs, logic [19:0] frac);
      calendar_t c;
      c = utc_breakdown(secs, frac);
      calendar_due_q.push_back(c);
      if (longint'(secs) + GPS_SHIFT + UNIX_SHIFT < 0) pre_1970++;
      leap_hits[c.leaps]++;
      if (int'(c.year) < year_lo) year_lo = c.year;
      if (int'(c.year) > year_hi) year_hi = c.year;
    endfunction

    function void check_result(calendar_t got);
      calendar_t want;
      if (calendar_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: result with nothing pending: %0d-%0d-%0d sod %0d",
                   got.year, got.month, got.mday, got.sod);
        return;
      end
      want = calendar_due_q.pop_front();
      checked++;
      if (got.year !== want.year || got.month !== want.month ||
          got.mday !== want.mday || got.sod !== want.sod ||
          got.frac !== want.frac || got.leaps !== want.leaps) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("ERROR: beat %0d exp y%0d m%0d d%0d sod %0d frac %h leaps %0d",
                   checked, want.year, want.month, want.mday, want.sod, want.frac,
                   want.leaps);
          $display("       got y%0d m%0d d%0d sod %0d frac %h leaps %0d",
                   got.year, got.month, got.mday, got.sod, got.frac, got.leaps);
        end
      end
    endfunction

    function int pending();
      return calendar_due_q.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [32:0] adjusted_seconds_i;
  logic [19:0]        fraction_magnitude_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [11:0]        calendar_year_o;
  logic [3:0]         month_index_o;
  logic [4:0]         day_of_month_o;
  logic [16:0]        seconds_of_day_o;
  logic [19:0]        fraction_out_o;
  logic [4:0]         leap_count_o;

  calendar_scoreboard sb;
  idle_e              src_mode;
  idle_e              sink_mode;

  gps_time_to_utc_calendar uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .adjusted_seconds_i   (adjusted_seconds_i),
    .fraction_magnitude_i (fraction_magnitude_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .calendar_year_o      (calendar_year_o),
    .month_index_o        (month_index_o),
    .day_of_month_o       (day_of_month_o),
    .seconds_of_day_o     (seconds_of_day_o),
    .fraction_out_o       (fraction_out_o),
    .leap_count_o         (leap_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Wait before the next beat, per the current spacing mode.
  function automatic int draw_wait(idle_e mode);
    case (mode)
      IDLE_NONE:   return 0;
      IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
      default:     return $urandom_range(0, 14);
    endcase
  endfunction

  function automatic idle_e pick_mode();
    case ($urandom_range(0, 3))
      0:       return IDLE_NONE;
      1:       return IDLE_SPARSE;
      default: return IDLE_FULL;
    endcase
  endfunction

  // Both handshakes are sampled at the rising edge, before any register update lands.
  always @(posedge clk_i) begin
    calendar_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.note_input(adjusted_seconds_i, fraction_magnitude_i);
      if (out_valid_o && out_ready_i) begin
        got.year  = calendar_year_o;
        got.month = month_index_o;
        got.mday  = day_of_month_o;
        got.sod   = seconds_of_day_o;
        got.frac  = fraction_out_o;
        got.leaps = leap_count_o;
        sb.check_result(got);
      end
    end
  end

  // Entered at a falling edge where valid is low or holds a beat already taken.
  // With no gap the next beat goes out in the same step, so valid never dips.
  task automatic send_beat(input longint secs, input logic [19:0] frac);
    int gap;
    gap = draw_wait(src_mode);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i           <= 1'b1;
    adjusted_seconds_i   <= secs[32:0];
    fraction_magnitude_i <= frac;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Hold the source off until the pipeline has handed back everything.
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Random whole seconds: uniform over all 33 bits, over the nominal range,
  // around leap thresholds, and around UTC midnights.
  function automatic longint rand_secs();
    longint day;
    case ($urandom_range(0, 9))
      0, 1, 2: return longint'({1'($urandom_range(0, 1)), 32'($urandom())}) -
                      (longint'(1) <<< 32);
      3, 4:    return longint'($urandom_range(0, 32'd4000000000)) - GPS_SHIFT;
      5, 6:    return calendar_scoreboard::leap_gps($urandom_range(0, LEAP_COUNT - 1)) -
                      GPS_SHIFT + longint'($urandom_range(0, 8)) - 4;
      7, 8: begin
        day = longint'($urandom_range(0, 98000)) - 34000;
        return day * DAY_SECS - GPS_SHIFT - UNIX_SHIFT +
               longint'($urandom_range(0, 40)) - 20;
      end
      default: return longint'($signed({1'($urandom_range(0, 1)), 32'($urandom())}));
    endcase
  endfunction

  function automatic logic [19:0] rand_frac();
    case ($urandom_range(0, 7))
      0:       return 20'h00000;
      1:       return 20'hFFFFF;
      default: return 20'($urandom());
    endcase
  endfunction

  // Sink: a fresh stall per result, drawn before ready is raised.
  initial begin
    int stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = draw_wait(sink_mode);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin
    int distinct;
    sb                   = new();
    src_mode             = IDLE_FULL;
    sink_mode            = IDLE_FULL;
    rst_ni               <= 1'b0;
    in_valid_i           <= 1'b0;
    adjusted_seconds_i   <= '0;
    fraction_magnitude_i <= '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, GPS epoch, leap edges, the Unix epoch,
    // century leap rules and a year boundary.
    send_beat(-(longint'(1) <<< 32), 20'h00000);       // most negative input, ~1875
    send_beat((longint'(1) <<< 32) - 1, 20'hFFFFF);   // most positive input, ~2147
    send_beat(0, 20'h80000);
    send_beat(-1, 20'h00001);                          // negative: fraction not borrowed
    send_beat(-GPS_SHIFT, 20'h7FFFF);                  // GPS epoch 1980-01-06
    send_beat(-GPS_SHIFT - 1, 20'h55555);
    send_beat(46828800 - GPS_SHIFT - 1, 20'hAAAAA);    // just short of the first leap
    send_beat(46828800 - GPS_SHIFT, 20'h12345);
    send_beat(599184012 - GPS_SHIFT, 20'h0F0F0);
    send_beat(1025136015 - GPS_SHIFT - 1, 20'hF0F0F); // last leap edge
    send_beat(1025136015 - GPS_SHIFT, 20'h00000);
    send_beat(-GPS_SHIFT - UNIX_SHIFT - 1, 20'hFFFFF); // one second before 1970
    send_beat(-GPS_SHIFT - UNIX_SHIFT, 20'h00010);
    send_beat(-64'sd3519856001, 20'h00100);            // 1900 has no Feb 29
    send_beat(-64'sd3519856000, 20'h01000);
    send_beat(-64'sd364182387, 20'h10000);             // 2000-02-29
    send_beat(-64'sd364095987, 20'h00002);
    send_beat(64'sd2791577615, 20'h00004);             // 2100 has no Feb 29
    send_beat(64'sd2791577616, 20'h00008);
    send_beat(64'sd261872015, 20'hFFFFE);              // across New Year 2020
    send_beat(64'sd261872016, 20'h00020);
    drain_pipe();

    // Random: spacing modes change by block; a full drain now and then.
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i % MODE_BLOCK == 0) begin
        src_mode  = pick_mode();
        sink_mode = pick_mode();
      end
      if (i > 0 && i % DRAIN_EVERY == 0) drain_pipe();
      send_beat(rand_secs(), rand_frac());
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    distinct = 0;
    foreach (sb.leap_hits[k]) if (sb.leap_hits[k] != 0) distinct++;
    $display("Checked %0d results, years %0d..%0d, %0d dated before 1970.",
             sb.checked, sb.year_lo, sb.year_hi, sb.pre_1970);
    $display("Leap counts seen: %0d of 17 values; %0d mismatches.", distinct,
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS gps_time_to_utc_calendar");
    end else begin
      $display("FAIL gps_time_to_utc_calendar");
    end
    $finish;
  end

  // Hang guard, several times the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding.", sb.pending());
    $display("FAIL gps_time_to_utc_calendar");
    $finish;
  end

endmodule
